/* rtl/core/cfra_pkg.sv */
`timescale 1ns / 1ps

package cfra_pkg;

   localparam int MAX_ORDER = 40;

   localparam int VALUE_W = 48;
   localparam int FRAC_W  = 32;
   localparam int DEN_W   = 33;
   localparam int TOL_W   = 32;
   localparam int ORDER_W = 6;
   localparam int PROD_W  = 64;

   localparam int DIV_STEPS = DEN_W;
   localparam int DIV_CNT_W = 6;

   localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(429);
   localparam logic [VALUE_W-1:0] NUM_MAX   = {VALUE_W{1'b1}};
   localparam logic [ORDER_W-1:0] ORDER_LAST = ORDER_W'(MAX_ORDER - 1);

   typedef struct packed {
      logic                 load;
      logic                 div_start;
      logic                 div_step;
      logic                 update;
      logic                 mult;
      logic                 emit;
      logic                 met;
      logic [ORDER_W-1:0]   order;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic within_tol;
   } sts_type;

endpackage

/* rtl/core/cfra_channels.sv */
`timescale 1ns / 1ps

interface cfra_req_if;
   import cfra_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value_in;
   modport source (output valid, output value_in, input ready);
   modport sink (input valid, input value_in, output ready);
endinterface

interface cfra_rsp_if;
   import cfra_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] numerator;
   logic [DEN_W-1:0]   denominator;
   logic [ORDER_W-1:0] order_used;
   logic               met_tolerance;
   modport source (output valid, output numerator, output denominator,
                   output order_used, output met_tolerance, input ready);
   modport sink (input valid, input numerator, input denominator,
                 input order_used, input met_tolerance, output ready);
endinterface

interface cfra_csr_if;
   import cfra_pkg::*;
   logic             valid;
   logic             ready;
   logic [TOL_W-1:0] tolerance;
   modport source (output valid, output tolerance, input ready);
   modport sink (input valid, input tolerance, output ready);
endinterface

/* rtl/core/cfra_datapath.sv */
`timescale 1ns / 1ps

module cfra_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cfra_pkg::cmd_type             cmd,
   output cfra_pkg::sts_type             sts,
   input  logic [cfra_pkg::VALUE_W-1:0]  value_in,
   input  logic                          csr_valid,
   input  logic [cfra_pkg::TOL_W-1:0]    csr_tolerance,
   output logic [cfra_pkg::VALUE_W-1:0]  numerator,
   output logic [cfra_pkg::DEN_W-1:0]    denominator,
   output logic [cfra_pkg::ORDER_W-1:0]  order_used,
   output logic                          met_tolerance
);
   import cfra_pkg::*;

   logic [TOL_W-1:0]   tol_ff, tol_in;
   logic [DEN_W-1:0]   div_ff, div_in;
   logic [FRAC_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0] p_ff, p_in, pp_ff, pp_in, pa_ff, pa_in;
   logic [DEN_W-1:0]   q_ff, q_in, qp_ff, qp_in, qa_ff, qa_in;
   logic [DEN_W-1:0]   dnd_ff, dnd_in;
   logic [FRAC_W-1:0]  part_ff, part_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VALUE_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [ORDER_W-1:0] ord_ff, ord_in;
   logic               met_ff, met_in;

   logic [DEN_W-1:0]   trial;
   logic               ge;
   logic [DEN_W-1:0]   trial_diff;
   logic [VALUE_W:0]   p_sum;
   logic [DEN_W:0]     q_sum;
   logic [PROD_W:0]    prod_full;

   assign trial      = {part_ff, dnd_ff[DEN_W-1]};
   assign ge         = trial >= {1'b0, rem_ff};
   assign trial_diff = trial - {1'b0, rem_ff};
   assign p_sum      = {1'b0, pa_ff} + {1'b0, pp_ff};
   assign q_sum      = {1'b0, qa_ff} + {1'b0, qp_ff};
   assign prod_full  = (PROD_W+1)'(tol_ff) * (PROD_W+1)'(q_ff);

   assign sts.rem_zero   = (rem_ff == '0);
   assign sts.within_tol = ({{(PROD_W-FRAC_W){1'b0}}, rem_ff} <= prod_ff);

   always_comb begin
      tol_in  = csr_valid ? csr_tolerance : tol_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      p_in    = p_ff;
      pp_in   = pp_ff;
      pa_in   = pa_ff;
      q_in    = q_ff;
      qp_in   = qp_ff;
      qa_in   = qa_ff;
      dnd_in  = dnd_ff;
      part_in = part_ff;
      prod_in = prod_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      ord_in  = ord_ff;
      met_in  = met_ff;
      if (cmd.load) begin
         div_in = {1'b1, {FRAC_W{1'b0}}};
         rem_in = value_in[FRAC_W-1:0];
         p_in   = {{FRAC_W{1'b0}}, value_in[VALUE_W-1:FRAC_W]};
         pp_in  = VALUE_W'(1);
         q_in   = DEN_W'(1);
         qp_in  = '0;
      end
      if (cmd.div_start) begin
         dnd_in  = div_ff;
         part_in = '0;
         pa_in   = '0;
         qa_in   = '0;
      end
      if (cmd.div_step) begin
         dnd_in  = {dnd_ff[DEN_W-2:0], 1'b0};
         part_in = ge ? trial_diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
         pa_in   = {pa_ff[VALUE_W-2:0], 1'b0} + (ge ? p_ff : '0);
         qa_in   = {qa_ff[DEN_W-2:0], 1'b0} + (ge ? q_ff : '0);
      end
      if (cmd.update) begin
         pp_in  = p_ff;
         qp_in  = q_ff;
         p_in   = p_sum[VALUE_W] ? NUM_MAX : p_sum[VALUE_W-1:0];
         q_in   = q_sum[DEN_W-1:0];
         div_in = {1'b0, rem_ff};
         rem_in = part_ff;
      end
      if (cmd.mult) begin
         prod_in = prod_full[PROD_W-1:0];
      end
      if (cmd.emit) begin
         num_in = p_ff;
         den_in = q_ff;
         ord_in = cmd.order;
         met_in = cmd.met;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      p_ff    <= p_in;
      pp_ff   <= pp_in;
      pa_ff   <= pa_in;
      q_ff    <= q_in;
      qp_ff   <= qp_in;
      qa_ff   <= qa_in;
      dnd_ff  <= dnd_in;
      part_ff <= part_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      ord_ff  <= ord_in;
      met_ff  <= met_in;
   end

   assign numerator     = num_ff;
   assign denominator   = den_ff;
   assign order_used    = ord_ff;
   assign met_tolerance = met_ff;

endmodule

/* rtl/core/cfra_controller.sv */
`timescale 1ns / 1ps

module cfra_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfra_pkg::cmd_type cmd,
   input  cfra_pkg::sts_type sts
);
   import cfra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_UPDATE,
      ST_MULT,
      ST_CMP,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic               met_ff, met_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      order_in     = order_ff;
      met_in       = met_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.order    = order_ff;
      cmd.met      = met_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               order_in = ORDER_W'(1);
               met_in   = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.rem_zero) begin
               met_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (sts.within_tol) begin
               met_in   = 1'b1;
               state_in = ST_DONE;
            end else if (order_ff == ORDER_LAST) begin
               state_in = ST_DONE;
            end else begin
               order_in = order_ff + ORDER_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         order_ff     <= '0;
         met_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         order_ff     <= order_in;
         met_ff       <= met_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("Result loaded while the output register is still full.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("Division step count ran past its end.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (order_ff != '0 && order_ff <= ORDER_LAST))
      else $error("Convergent order out of range.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && !sts.within_tol && order_ff == ORDER_LAST)
         |=> (state_ff == ST_DONE && !met_ff))
      else $error("Order limit did not end the expansion.");

endmodule

/* rtl/core/continued_fraction_rational_approx.sv */
`timescale 1ns / 1ps
// An input with zero fraction goes from the check straight to the result, with no division.
// Otherwise each order runs a check, a restoring division, update, multiply and compare; the
// limit of 39 orders bounds the expansion.
// One item at a time: the next transfer is taken once the result is loaded.
// Reset is synchronous and active high; it clears the controller and sets tolerance to 429.
module continued_fraction_rational_approx (
   input logic        clock,
   input logic        reset,
   cfra_req_if.sink   req_if,
   cfra_rsp_if.source rsp_if,
   cfra_csr_if.sink   csr_if
);
   import cfra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_if.ready = 1'b1;

   cfra_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cfra_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .value_in      (req_if.value_in),
      .csr_valid     (csr_if.valid),
      .csr_tolerance (csr_if.tolerance),
      .numerator     (rsp_if.numerator),
      .denominator   (rsp_if.denominator),
      .order_used    (rsp_if.order_used),
      .met_tolerance (rsp_if.met_tolerance)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import cfra_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] numerator;
      logic [DEN_W-1:0]   denominator;
      logic [ORDER_W-1:0] order_used;
      logic               met_tolerance;
   } approx_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      approx_type         want;
   } pending_type;

   typedef struct {
      logic [TOL_W-1:0]   tol;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      approx_type         want;
   } vector_type;

   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 40;
   localparam int REPORT_LIMIT  = 10;

   logic clock;
   logic reset;

   cfra_req_if req_if ();
   cfra_rsp_if rsp_if ();
   cfra_csr_if csr_if ();

   continued_fraction_rational_approx dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   pending_type      pending [$];
   vector_type       vectors [$];
   logic [TOL_W-1:0] tol_now = TOL_RESET;
   int               mismatches = 0;
   bit               steady = 1'b0;
   int               stall_left = 0;
   int               pick;
   approx_type       seen;
   pending_type      head;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("** continued_fraction_rational_approx: FAILED **");
      $finish;
   end

   // Convergent search: Euclid on (value, 2^32), first convergent within tolerance, or the last one at the order limit.
   function automatic approx_type best_fraction(input logic [VALUE_W-1:0] v,
                                                input logic [TOL_W-1:0] tol);
      logic [63:0] p_old, q_old, p_cur, q_cur, dvd, rmd, quo, nrem, p_new, q_new;
      approx_type  r;
      p_old = 64'd1;
      q_old = 64'd0;
      p_cur = 64'(v[VALUE_W-1:FRAC_W]);
      q_cur = 64'd1;
      dvd   = 64'h1_0000_0000;
      rmd   = 64'(v[FRAC_W-1:0]);
      r.met_tolerance = 1'b0;
      r.order_used    = '0;
      if (rmd == 64'd0) begin
         r.numerator     = 48'(p_cur);
         r.denominator   = 33'd1;
         r.order_used    = 6'd1;
         r.met_tolerance = 1'b1;
         return r;
      end
      for (int k = 1; k < MAX_ORDER; k++) begin
         r.order_used = ORDER_W'(k);
         if (rmd == 64'd0) begin
            r.met_tolerance = 1'b1;
            break;
         end
         quo   = dvd / rmd;
         nrem  = dvd % rmd;
         p_new = quo * p_cur + p_old;
         q_new = quo * q_cur + q_old;
         p_old = p_cur;
         q_old = q_cur;
         p_cur = p_new;
         q_cur = q_new;
         dvd   = rmd;
         rmd   = nrem;
         if (rmd <= 64'(tol) * q_cur) begin
            r.met_tolerance = 1'b1;
            break;
         end
      end
      if (p_cur > 64'(NUM_MAX)) begin
         p_cur = 64'(NUM_MAX);
      end
      r.numerator   = p_cur[VALUE_W-1:0];
      r.denominator = q_cur[DEN_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      logic [63:0] num, den, wide, off;
      int          kind;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         den  = 64'($urandom_range(1, 2000));
         num  = 64'($urandom_range(0, 32'(den * 65535)));
         wide = (num << 32) / den;
      end else if (kind < 60) begin
         wide = 64'({16'($urandom_range(0, 3)), 32'($urandom)});
      end else if (kind < 75) begin
         wide = {$urandom, $urandom};
      end else if (kind < 83) begin
         wide = 64'({16'($urandom), 32'h0});
      end else if (kind < 91) begin
         off  = 64'($urandom_range(1, 4095));
         wide = 64'({16'($urandom), 32'h0});
         wide = $urandom_range(0, 1) ? wide + off : wide - off;
      end else begin
         wide = 64'({16'($urandom_range(0, 15)), 32'h9E37_79B9 ^ 32'($urandom_range(0, 255))});
      end
      return wide[VALUE_W-1:0];
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   task automatic wait_drained();
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic offer_value(input logic [VALUE_W-1:0] v, input approx_type want);
      pending_type e;
      req_if.valid    <= 1'b1;
      req_if.value_in <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      e.value = v;
      e.want  = want;
      pending.push_back(e);
   endtask

   task automatic pause_sender();
      int gap;
      gap = sender_gap();
      if (!steady && $urandom_range(0, 39) == 0) begin
         req_if.valid <= 1'b0;
         wait_drained();
      end else if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_tolerance(input logic [TOL_W-1:0] t);
      req_if.valid <= 1'b0;
      wait_drained();
      csr_if.valid     <= 1'b1;
      csr_if.tolerance <= t;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      tol_now = t;
   endtask

   task automatic add_row(input logic [TOL_W-1:0] t, input logic [VALUE_W-1:0] v,
                          input bit typed, input logic [VALUE_W-1:0] num,
                          input logic [DEN_W-1:0] den, input int ord, input bit met);
      vector_type row;
      row.tol   = t;
      row.value = v;
      row.typed = typed;
      row.want  = '{num, den, ORDER_W'(ord), met};
      vectors.push_back(row);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.numerator     = rsp_if.numerator;
            seen.denominator   = rsp_if.denominator;
            seen.order_used    = rsp_if.order_used;
            seen.met_tolerance = rsp_if.met_tolerance;
            if (pending.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result %h/%h order %0d met %b", seen.numerator,
                           seen.denominator, seen.order_used, seen.met_tolerance);
               end
            end else begin
               head = pending.pop_front();
               if (seen !== head.want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("value %h: expected %h/%h order %0d met %b, ",
                              head.value, head.want.numerator, head.want.denominator,
                              head.want.order_used, head.want.met_tolerance,
                              "got %h/%h order %0d met %b",
                              seen.numerator, seen.denominator, seen.order_used,
                              seen.met_tolerance);
                  end
               end
            end
         end
         pick = $urandom_range(0, 99);
         if (steady) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (pick < 70) begin
            rsp_if.ready <= 1'b1;
         end else if (pick < 95) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(10, 60);
         end
      end
   end

   initial begin : stimulus
      logic [TOL_W-1:0]   t;
      logic [VALUE_W-1:0] v;
      approx_type         want;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.value_in  <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.tolerance <= '0;

      add_row(TOL_RESET, 48'h0000_0000_0000, 1, 48'd0, 33'd1, 1, 1);
      add_row(TOL_RESET, 48'h0005_0000_0000, 1, 48'd5, 33'd1, 1, 1);
      add_row(TOL_RESET, 48'hFFFF_0000_0000, 1, 48'd65535, 33'd1, 1, 1);
      add_row(TOL_RESET, 48'h0000_8000_0000, 1, 48'd1, 33'd2, 1, 1);
      add_row(TOL_RESET, 48'h0000_0000_0001, 1, 48'd1, 33'h1_0000_0000, 1, 1);
      add_row(TOL_RESET, 48'hFFFF_FFFF_FFFF, 1, 48'd65536, 33'd1, 1, 1);
      add_row(TOL_RESET, 48'h0000_FFFF_FFFF, 1, 48'd1, 33'd1, 1, 1);
      add_row(TOL_RESET, 48'h0003_243F_6A89, 0, '0, '0, 0, 0);
      add_row(TOL_RESET, 48'h0000_9E37_79B9, 0, '0, '0, 0, 0);
      add_row(TOL_RESET, 48'h0001_6A09_E667, 0, '0, '0, 0, 0);
      add_row(32'd0, 48'h0000_9E37_79B9, 0, '0, '0, 0, 0);
      add_row(32'd0, 48'h0000_5555_5555, 0, '0, '0, 0, 0);
      add_row(32'd0, 48'h0001_0000_0001, 1, 48'h1_0000_0001, 33'h1_0000_0000, 1, 1);
      add_row(32'd0, 48'h0002_B7E1_5163, 0, '0, '0, 0, 0);
      add_row(32'hFFFF_FFFF, 48'h0000_9E37_79B9, 1, 48'd1, 33'd1, 1, 1);
      add_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 48'd65536, 33'd1, 1, 1);
      add_row(32'hFFFF_FFFF, 48'h0000_0000_0001, 1, 48'd1, 33'h1_0000_0000, 1, 1);
      add_row(32'd1, 48'h0000_4000_0000, 1, 48'd1, 33'd4, 1, 1);
      add_row(32'd1, 48'h7FFF_AAAA_5555, 0, '0, '0, 0, 0);
      add_row(32'd1, 48'h0000_0000_FFFF, 0, '0, '0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].tol != tol_now) begin
            set_tolerance(vectors[i].tol);
         end
         want = vectors[i].typed ? vectors[i].want
                                 : best_fraction(vectors[i].value, tol_now);
         offer_value(vectors[i].value, want);
         pause_sender();
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: t = TOL_RESET;
            1: t = 32'd0;
            2: t = 32'd1;
            3: t = 32'($urandom_range(2, 5000));
            4: t = 32'hFFFF_FFFF;
            5: t = 32'($urandom);
            default: t = 32'($urandom_range(5000, 1000000));
         endcase
         set_tolerance(t);
         steady = (ph == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            v = random_value();
            offer_value(v, best_fraction(v, tol_now));
            pause_sender();
         end
         steady = 1'b0;
      end

      req_if.valid <= 1'b0;
      wait_drained();
      repeat (1600) @(posedge clock);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("** continued_fraction_rational_approx: PASSED **");
      end else begin
         $display("** continued_fraction_rational_approx: FAILED **");
      end
      $finish;
   end

endmodule
